@@ src/tps_pkg.sv @@
// Shared types and constants for the threshold run pixel line sorter.
package tps_pkg;

  // Sort key selection
  localparam logic [2:0] KEY_AVG  = 3'd0;
  localparam logic [2:0] KEY_PROD = 3'd1;
  localparam logic [2:0] KEY_MAX  = 3'd2;
  localparam logic [2:0] KEY_MIN  = 3'd3;

  // Run modes
  localparam logic [1:0] RUN_ALL   = 2'd0;
  localparam logic [1:0] RUN_DARK  = 2'd1;
  localparam logic [1:0] RUN_LIGHT = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_KEY_MODE  = 2'd0;
  localparam logic [1:0] CFG_RUN_MODE  = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD = 2'd2;

  localparam logic [23:0] THRESHOLD_RESET = 24'd127;

  // Reciprocal of three for sums up to 765: floor(x * 683 / 2048)
  localparam logic [9:0] RECIP3      = 10'd683;
  localparam int         RECIP3_SHIFT = 11;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PRIME,
    ST_KEY,
    ST_SORT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic prime;
    logic rotate;
    logic sort;
    logic parity;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
  } stat_t;

endpackage

@@ src/tps_ctrl.sv @@
// Controller state machine: load, key pass, sort phases and emission.
module tps_ctrl #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           line_end,
  input  tps_pkg::stat_t stat,
  output tps_pkg::cmd_t  cmd,
  output logic           busy
);

  localparam int CNT_W = $clog2(LINE_CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(LINE_CAPACITY - 1);

  tps_pkg::state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  // State and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tps_pkg::ST_LOAD;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.parity = cnt[0];
    busy       = 1'b1;
    unique case (state)
      tps_pkg::ST_LOAD: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (line_end) state_next = tps_pkg::ST_PRIME;
        end
      end
      tps_pkg::ST_PRIME: begin
        cmd.prime  = 1'b1;
        cnt_next   = '0;
        state_next = tps_pkg::ST_KEY;
      end
      tps_pkg::ST_KEY: begin
        cmd.rotate = 1'b1;
        if (cnt == CNT_END) begin
          cnt_next   = '0;
          state_next = tps_pkg::ST_SORT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      tps_pkg::ST_SORT: begin
        cmd.sort = 1'b1;
        if (cnt == CNT_END) begin
          cnt_next   = '0;
          state_next = tps_pkg::ST_EMIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      tps_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.last) state_next = tps_pkg::ST_LOAD;
      end
      default: state_next = tps_pkg::ST_LOAD;
    endcase
  end

endmodule

@@ src/tps_datapath.sv @@
// Datapath: pixel cells, key unit, segmented odd-even sorter and output shift.
module tps_datapath #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  tps_pkg::cmd_t  cmd,
  output tps_pkg::stat_t stat,
  input  logic [7:0]     red,
  input  logic [7:0]     green,
  input  logic [7:0]     blue,
  input  logic [7:0]     alpha,
  input  logic           cfg_valid,
  input  logic [1:0]     cfg_index,
  input  logic [23:0]    cfg_data,
  output logic [7:0]     out_red,
  output logic [7:0]     out_green,
  output logic [7:0]     out_blue,
  output logic [7:0]     out_alpha
);

  localparam int CAP   = LINE_CAPACITY;
  localparam int IDX_W = $clog2(CAP);
  localparam int CNT_W = $clog2(CAP + 1);
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAP);

  logic [2:0]  key_mode;
  logic [1:0]  run_mode;
  logic [23:0] threshold;

  logic [CNT_W-1:0] fill_count;

  logic [31:0] pix [CAP];
  logic [23:0] key [CAP];
  logic        fix [CAP];
  logic [31:0] pix_next [CAP];
  logic [23:0] key_next [CAP];
  logic        fix_next [CAP];

  logic [15:0] rg;
  logic [15:0] rg_src;
  logic [7:0]  kr, kg, kb, hi, lo;
  logic [9:0]  sum;
  logic [19:0] avg_prod;
  logic [23:0] new_key;
  logic        new_fix;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_mode  <= '0;
      run_mode  <= '0;
      threshold <= tps_pkg::THRESHOLD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tps_pkg::CFG_KEY_MODE:  key_mode  <= cfg_data[2:0];
        tps_pkg::CFG_RUN_MODE:  run_mode  <= cfg_data[1:0];
        tps_pkg::CFG_THRESHOLD: threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Fill count: up on load until full, down on each emitted pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (cmd.load && fill_count != CNT_CAP) begin
      fill_count <= fill_count + 1'b1;
    end else if (cmd.emit) begin
      fill_count <= fill_count - 1'b1;
    end
  end

  assign stat.last = (fill_count == CNT_W'(1));

  // Key unit on cell 0; red times green is registered the cycle before the pixel is keyed
  assign rg_src = cmd.prime ? pix[0][7:0] * pix[0][15:8] : pix[1][7:0] * pix[1][15:8];

  always_ff @(posedge clk) begin
    rg <= rg_src;
  end

  always_comb begin
    kr = pix[0][7:0];
    kg = pix[0][15:8];
    kb = pix[0][23:16];
    hi = kr;
    lo = kr;
    if (kg > hi) hi = kg;
    if (kb > hi) hi = kb;
    if (kg < lo) lo = kg;
    if (kb < lo) lo = kb;
    sum      = 10'(kr) + 10'(kg) + 10'(kb);
    avg_prod = 20'(sum) * 20'(tps_pkg::RECIP3);
    case (key_mode)
      tps_pkg::KEY_AVG:  new_key = 24'(avg_prod >> tps_pkg::RECIP3_SHIFT);
      tps_pkg::KEY_PROD: new_key = 24'(rg * kb);
      tps_pkg::KEY_MAX:  new_key = 24'(hi);
      tps_pkg::KEY_MIN:  new_key = 24'(lo);
      default:           new_key = 24'(kr ^ kg ^ kb);
    endcase
    case (run_mode)
      tps_pkg::RUN_DARK:  new_fix = (new_key <= threshold);
      tps_pkg::RUN_LIGHT: new_fix = (new_key >= threshold);
      default:            new_fix = 1'b0;
    endcase
  end

  // Next cell contents
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      pix_next[i] = pix[i];
      key_next[i] = key[i];
      fix_next[i] = fix[i];
    end
    if (cmd.load && fill_count != CNT_CAP) begin
      pix_next[fill_count[IDX_W-1:0]] = {alpha, blue, green, red};
    end
    if (cmd.rotate) begin
      // rotate the whole row, keying the pixel that wraps round
      for (int i = 0; i < CAP - 1; i++) begin
        pix_next[i] = pix[i+1];
        key_next[i] = key[i+1];
        fix_next[i] = fix[i+1];
      end
      pix_next[CAP-1] = pix[0];
      key_next[CAP-1] = new_key;
      fix_next[CAP-1] = new_fix;
    end
    if (cmd.sort) begin
      // one odd-even phase; fixed pixels and the unfilled tail bound the runs
      for (int i = 0; i < CAP - 1; i++) begin
        if ((i % 2) == int'(cmd.parity) && (CNT_W'(i + 1) < fill_count) &&
            !fix[i] && !fix[i+1] && key[i] > key[i+1]) begin
          pix_next[i]   = pix[i+1];
          pix_next[i+1] = pix[i];
          key_next[i]   = key[i+1];
          key_next[i+1] = key[i];
        end
      end
    end
    if (cmd.emit) begin
      for (int i = 0; i < CAP - 1; i++) begin
        pix_next[i] = pix[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAP; i++) begin
      pix[i] <= pix_next[i];
      key[i] <= key_next[i];
      fix[i] <= fix_next[i];
    end
  end

  assign out_red   = pix[0][7:0];
  assign out_green = pix[0][15:8];
  assign out_blue  = pix[0][23:16];
  assign out_alpha = pix[0][31:24];

endmodule

@@ src/threshold_run_pixel_line_sorter.sv @@
// Top level of the threshold run pixel line sorter.
// Pixels are loaded one per cycle while busy is low; the pixel with line_end
// set closes the line (pixels beyond LINE_CAPACITY are dropped). The block
// then goes busy for a priming step, a key pass that rotates the whole cell
// row through the single key unit, LINE_CAPACITY odd-even sort phases, and
// the emission of the n pixels of the line on out_valid, the last with
// out_last.
// Results cannot be held off: each is on the ports for one cycle only.
module threshold_run_pixel_line_sorter #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  alpha,
  input  logic        line_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic        out_last
);

  tps_pkg::cmd_t  cmd;
  tps_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  tps_ctrl #(.LINE_CAPACITY(LINE_CAPACITY)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .line_end (line_end),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  tps_datapath #(.LINE_CAPACITY(LINE_CAPACITY)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha     (alpha),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha)
  );

  assign out_valid = cmd.emit;
  assign out_last  = cmd.emit & stat.last;

`ifndef NO_ASSERTIONS
  // results only while the block is busy
  a_out_busy: assert property (@(posedge clk) disable iff (rst) out_valid |-> busy)
    else $error("result outside busy period");
  // a pixel without line end keeps the block loading
  a_no_end: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !line_end) |=> !busy)
    else $error("busy after a mid-line pixel");
  // the marked last result ends emission
  a_last_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |=> (!out_valid && !busy))
    else $error("emission continues after last pixel");
`endif

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the threshold run pixel line sorter.
`timescale 1ns / 1ps

module testbench;

  localparam int CAP = 64;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       last;
  } pixel_t;

  typedef struct packed {
    logic       is_cfg;
    logic [1:0] idx;
    logic [23:0] data;
    pixel_t     px;
  } request_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [7:0]  red, green, blue, alpha;
  logic        line_end;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        out_valid;
  logic [7:0]  out_red, out_green, out_blue, out_alpha;
  logic        out_last;

  threshold_run_pixel_line_sorter #(.LINE_CAPACITY(CAP)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .red(red), .green(green), .blue(blue), .alpha(alpha), .line_end(line_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_red(out_red),
    .out_green(out_green), .out_blue(out_blue), .out_alpha(out_alpha),
    .out_last(out_last)
  );

  // Sorter shadow state
  pixel_t      line_buf[$];
  logic [2:0]  key_sel;
  logic [1:0]  run_sel;
  logic [23:0] thresh;

  request_t    pending[$];
  pixel_t      expected_pixels[$];
  int          mismatches;
  int          idle_cycles;
  int          gap;
  bit          quiet;
  bit          stim_done;

  function automatic logic [23:0] key_of(pixel_t p);
    logic [9:0] s;
    logic [7:0] hi, lo;
    s = 10'(p.r) + 10'(p.g) + 10'(p.b);
    hi = p.r; lo = p.r;
    if (p.g > hi) hi = p.g;
    if (p.b > hi) hi = p.b;
    if (p.g < lo) lo = p.g;
    if (p.b < lo) lo = p.b;
    case (key_sel)
      tps_pkg::KEY_AVG:  return 24'(s / 10'd3);
      tps_pkg::KEY_PROD: return 24'(p.r) * 24'(p.g) * 24'(p.b);
      tps_pkg::KEY_MAX:  return 24'(hi);
      tps_pkg::KEY_MIN:  return 24'(lo);
      default:           return 24'(p.r ^ p.g ^ p.b);
    endcase
  endfunction

  function automatic bit fixed_key(logic [23:0] k);
    if (run_sel == tps_pkg::RUN_DARK) return k <= thresh;
    if (run_sel == tps_pkg::RUN_LIGHT) return k >= thresh;
    return 0;
  endfunction

  // Stable insertion sort of each sortable span, then queue the line
  task automatic sort_and_expect();
    pixel_t      px[$];
    logic [23:0] k[$];
    int i, j, lo, n;
    pixel_t tp;
    logic [23:0] tk;
    px = line_buf;
    n = px.size();
    for (i = 0; i < n; i++) k.push_back(key_of(px[i]));
    i = 0;
    while (i < n) begin
      while (i < n && fixed_key(k[i])) i++;
      lo = i;
      while (i < n && !fixed_key(k[i])) i++;
      for (int m = lo + 1; m < i; m++) begin
        tk = k[m]; tp = px[m]; j = m;
        while (j > lo && k[j-1] > tk) begin
          k[j] = k[j-1]; px[j] = px[j-1]; j--;
        end
        k[j] = tk; px[j] = tp;
      end
    end
    for (i = 0; i < n; i++) begin
      tp = px[i];
      tp.last = (i == n - 1);
      expected_pixels.push_back(tp);
    end
    line_buf.delete();
  endtask

  task automatic push_pixel(logic [7:0] r, g, b, a, logic e);
    request_t q;
    q = '0;
    q.px = '{r, g, b, a, e};
    pending.push_back(q);
  endtask

  task automatic push_cfg(logic [1:0] idx, logic [23:0] d);
    request_t q;
    q = '0;
    q.is_cfg = 1; q.idx = idx; q.data = d;
    pending.push_back(q);
  endtask

  task automatic push_line(int n);
    for (int i = 0; i < n; i++)
      push_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), i == n - 1);
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Stimulus plan
  initial begin
    mismatches = 0;
    key_sel = tps_pkg::KEY_AVG; run_sel = tps_pkg::RUN_ALL;
    thresh = tps_pkg::THRESHOLD_RESET;
    // directed: extremes, single pixel, reset threshold in dark mode
    push_pixel(8'hff, 8'hff, 8'hff, 8'hff, 0);
    push_pixel(8'h00, 8'h00, 8'h00, 8'h00, 0);
    push_pixel(8'h80, 8'h01, 8'hfe, 8'h7f, 0);
    push_pixel(8'h80, 8'h01, 8'hfe, 8'h11, 1);
    push_pixel(8'h12, 8'h34, 8'h56, 8'h78, 1);
    push_cfg(tps_pkg::CFG_RUN_MODE, 24'(tps_pkg::RUN_DARK));
    push_line(6);
    push_cfg(tps_pkg::CFG_KEY_MODE, 24'(tps_pkg::KEY_PROD));
    push_cfg(tps_pkg::CFG_RUN_MODE, 24'(tps_pkg::RUN_LIGHT));
    push_cfg(tps_pkg::CFG_THRESHOLD, 24'hffffff);
    push_line(5);
    push_cfg(tps_pkg::CFG_KEY_MODE, 24'd7);
    push_cfg(tps_pkg::CFG_RUN_MODE, 24'd3);
    push_cfg(tps_pkg::CFG_THRESHOLD, 24'd0);
    push_line(4);
    // overlong line: pixels past capacity are dropped
    push_cfg(tps_pkg::CFG_KEY_MODE, 24'(tps_pkg::KEY_MAX));
    push_line(CAP + 3);
    // random lines through varied settings
    for (int l = 0; l < 6; l++) begin
      push_cfg(tps_pkg::CFG_KEY_MODE, 24'($urandom_range(0, 7)));
      push_cfg(tps_pkg::CFG_RUN_MODE, 24'($urandom_range(0, 3)));
      push_cfg(tps_pkg::CFG_THRESHOLD,
               ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 255)));
      push_line($urandom_range(1, 6));
    end
    push_cfg(tps_pkg::CFG_KEY_MODE, 24'(tps_pkg::KEY_MIN));
    push_cfg(tps_pkg::CFG_RUN_MODE, 24'(tps_pkg::RUN_DARK));
    push_cfg(tps_pkg::CFG_THRESHOLD, 24'd100);
    push_line(10);
  end

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 0; cfg_valid <= 0; gap <= 0; stim_done <= 0;
    end else begin
      if (start && !busy) begin
        request_t r;
        pixel_t p;
        r = pending.pop_front();
        p = r.px;
        if (line_buf.size() < CAP) line_buf.push_back(p);
        if (p.last) sort_and_expect();
      end
      if (cfg_valid && cfg_ready) begin
        request_t c;
        c = pending.pop_front();
        case (c.idx)
          tps_pkg::CFG_KEY_MODE:  key_sel <= c.data[2:0];
          tps_pkg::CFG_RUN_MODE:  run_sel <= c.data[1:0];
          default:                thresh <= c.data;
        endcase
      end
      if ((start && !busy) || (cfg_valid && cfg_ready) || (!start && !cfg_valid)) begin
        start <= 0; cfg_valid <= 0;
        if (gap > 0) gap <= gap - 1;
        else if (!quiet && pending.size() > 20 && $urandom_range(0, 3) == 0)
          gap <= $urandom_range(1, 5);
        else if (pending.size() == 0) stim_done <= 1;
        else begin
          request_t n;
          // any request accepted this edge has already left the queue
          n = pending[0];
          if (n.is_cfg) begin
            // writes wait until the line in flight has fully drained
            if (expected_pixels.size() == 0 && line_buf.size() == 0 && !busy) begin
              cfg_valid <= 1; cfg_index <= n.idx; cfg_data <= n.data;
            end
          end else begin
            start <= 1;
            red <= n.px.r; green <= n.px.g; blue <= n.px.b;
            alpha <= n.px.a; line_end <= n.px.last;
          end
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel out %h%h%h%h", out_red, out_green,
                                       out_blue, out_alpha);
      end else begin
        pixel_t e;
        e = expected_pixels.pop_front();
        if ({out_red, out_green, out_blue, out_alpha, out_last} !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected r%h g%h b%h a%h l%b, got r%h g%h b%h a%h l%b",
                     e.r, e.g, e.b, e.a, e.last,
                     out_red, out_green, out_blue, out_alpha, out_last);
        end
      end
    end
  end

  // Watchdog on progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!rst && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst = 1; start = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    red = 0; green = 0; blue = 0; alpha = 0; line_end = 0;
    quiet = 0; idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    wait (pending.size() < 30);
    quiet = 1;
    wait (stim_done);
    wait (expected_pixels.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
src/tps_pkg.sv
src/tps_ctrl.sv
src/tps_datapath.sv
src/threshold_run_pixel_line_sorter.sv
sim/testbench.sv
